FILE: sv/tbo_pkg.sv
`default_nettype none
package tbo_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int HALF_BITS      = 23;
  localparam logic [HALF_BITS-1:0] HALF_RESET = 23'd2048;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_Z = 2'd2;

  localparam int Q_DEPTH_DEF = 4;
  localparam int OUT_W       = 8;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

FILE: sv/triangle_box_overlap_test_core.sv
`default_nettype none
// Triangle against axis-aligned box overlap test by separating axes. Each
// input beat carries three vertices and a box centre in signed fixed point;
// the box half sizes come from three configuration registers (write them
// only while the block is idle). The block accepts one beat per clock
// unless its front register is held by a full queue, and returns one
// result beat per input beat, in order. A front stage forms vertex
// offsets and edges and pushes them into a four-entry queue; a
// seven-stage back pipeline evaluates all thirteen axes with exact integer
// products. Throughput is one item per cycle, set by the back pipeline,
// which advances whenever its output register is empty or being taken.
module triangle_box_overlap_test_core import tbo_pkg::*; #(
  parameter  int COORD_BITS = COORD_BITS_DEF,
  localparam int IN_W       = ((12 * COORD_BITS + 7) / 8) * 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
  // vert_c_x, vert_c_y, vert_c_z, centre_x, centre_y, centre_z
  input  wire logic [IN_W-1:0]       in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // overlaps
  output logic [OUT_W-1:0]           out_tdata,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [HALF_BITS-1:0]  cfg_data
);

  localparam int ITEM_W = 27 * (COORD_BITS + 1);

  logic [HALF_BITS-1:0] half_x_r;
  logic [HALF_BITS-1:0] half_y_r;
  logic [HALF_BITS-1:0] half_z_r;
  logic                 q_push;
  logic                 q_pop;
  logic [ITEM_W-1:0]    q_item;
  logic [ITEM_W-1:0]    q_data;
  q_stat_t              q_stat;
  logic                 overlaps;

  assign cfg_ready = 1'b1;
  assign out_tdata = {(OUT_W-1)'(0), overlaps};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_x_r <= HALF_RESET;
      half_y_r <= HALF_RESET;
      half_z_r <= HALF_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_HALF_X: half_x_r <= cfg_data;
        CFG_HALF_Y: half_y_r <= cfg_data;
        CFG_HALF_Z: half_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  tbo_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_data  (in_tdata),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_item   (q_item)
  );

  tbo_queue #(.WIDTH(ITEM_W), .DEPTH(Q_DEPTH_DEF)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_item),
    .pop       (q_pop),
    .pop_data  (q_data),
    .stat      (q_stat)
  );

  tbo_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_stat       (q_stat),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .half_x       (half_x_r),
    .half_y       (half_y_r),
    .half_z       (half_z_r),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_overlaps (overlaps)
  );

endmodule
`default_nettype wire

FILE: sv/tbo_front.sv
`default_nettype none
module tbo_front import tbo_pkg::*; #(
  parameter  int COORD_BITS = COORD_BITS_DEF,
  localparam int VW         = COORD_BITS + 1,
  localparam int IN_W       = ((12 * COORD_BITS + 7) / 8) * 8,
  localparam int ITEM_W     = 27 * VW
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [IN_W-1:0]   in_data,
  input  wire q_stat_t           q_stat,
  output logic                   q_push,
  output logic [ITEM_W-1:0]      q_item
);

  logic signed [COORD_BITS-1:0] crd [12];
  logic signed [VW-1:0] v_nxt [3][3];
  logic signed [VW-1:0] e_nxt [3][3];
  logic signed [VW-1:0] v_r   [3][3];
  logic signed [VW-1:0] e_r   [3][3];
  logic        [VW-1:0] ae    [3][3];
  logic                 valid_r;
  logic                 adv;

  always_comb begin
    for (int f = 0; f < 12; f++) begin
      crd[f] = in_data[f*COORD_BITS +: COORD_BITS];
    end
    // Edges are taken straight from the vertices; the centre cancels out.
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        v_nxt[i][k] = VW'(crd[i*3+k]) - VW'(crd[9+k]);
        e_nxt[i][k] = VW'(crd[((i+1)%3)*3+k]) - VW'(crd[i*3+k]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        ae[i][k] = e_r[i][k][VW-1] ? VW'(-e_r[i][k]) : VW'(e_r[i][k]);
        q_item[(i*3+k)*VW +: VW]      = v_r[i][k];
        q_item[(9+i*3+k)*VW +: VW]    = e_r[i][k];
        q_item[(18+i*3+k)*VW +: VW]   = ae[i][k];
      end
    end
  end

  assign adv      = !valid_r || !q_stat.full;
  assign in_ready = adv;
  assign q_push   = valid_r && !q_stat.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      v_r <= v_nxt;
      e_r <= e_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/tbo_queue.sv
`default_nettype none
module tbo_queue import tbo_pkg::*; #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = Q_DEPTH_DEF,
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output q_stat_t               stat
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CW-1:0]    cnt_r;
  logic [CW-1:0]    cnt_nxt;

  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign cnt_nxt    = cnt_r + CW'(push) - CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

FILE: sv/tbo_back.sv
`default_nettype none
module tbo_back import tbo_pkg::*; #(
  parameter  int COORD_BITS = COORD_BITS_DEF,
  localparam int VW     = COORD_BITS + 1,
  localparam int EW     = VW,
  localparam int HW     = HALF_BITS,
  localparam int MW     = (VW > HW) ? VW : HW,
  localparam int ITEM_W = 27 * VW,
  localparam int BW     = MW + 2,
  localparam int EPW    = EW + VW,
  localparam int ESW    = EPW + 1,
  localparam int ERW    = HW + EW + 1,
  localparam int ECW    = EW + MW + 3,
  localparam int NW     = 2 * EW + 1,
  localparam int NL     = (NW + 1) / 2,
  localparam int NH     = NW - NL,
  localparam int PLW    = NL + 1 + VW,
  localparam int PHW    = NH + VW,
  localparam int RLW    = NL + HW,
  localparam int RHW    = NH + HW,
  localparam int SW     = NW + MW + 4,
  localparam int NSTG   = 7
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire q_stat_t           q_stat,
  input  wire logic [ITEM_W-1:0] q_data,
  output logic                   q_pop,
  input  wire logic [HW-1:0]     half_x,
  input  wire logic [HW-1:0]     half_y,
  input  wire logic [HW-1:0]     half_z,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_overlaps
);

  logic [NSTG-1:0] vld_r;
  logic            adv;

  logic        [HW-1:0] h [3];
  logic signed [VW-1:0] v  [3][3];
  logic signed [EW-1:0] e  [3][3];
  logic        [EW-1:0] ae [3][3];

  // Stage 1: box normals, normal cross terms, edge axis products.
  logic                    bsep_c;
  logic signed [2*EW-1:0]  np_c [3][2];
  logic signed [EPW-1:0]   m_c  [3][3][2][2];
  logic        [ERW-2:0]   rp_c [3][3][2];
  logic signed [2*EW-1:0]  np_r [3][2];
  logic signed [EPW-1:0]   m_r  [3][3][2][2];
  logic        [ERW-2:0]   rp_r [3][3][2];
  logic signed [VW-1:0]    v0_1_r [3];
  logic                    bsep_r;

  // Stage 2: normal components, edge projections and radii.
  logic signed [NW-1:0]    n_nxt [3];
  logic signed [ESW-1:0]   p_nxt [3][3][2];
  logic        [ERW-1:0]   r_nxt [3][3];
  logic signed [NW-1:0]    n2_r  [3];
  logic signed [ESW-1:0]   p2_r  [3][3][2];
  logic        [ERW-1:0]   r2_r  [3][3];
  logic signed [VW-1:0]    v0_2_r [3];
  logic                    sep2_r;

  // Stage 3: edge axis decisions, normal magnitude.
  logic                    esep_c;
  logic        [NW-1:0]    an_c  [3];
  logic signed [NW-1:0]    n3_r  [3];
  logic        [NW-1:0]    an3_r [3];
  logic signed [VW-1:0]    v0_3_r [3];
  logic                    sep3_r;

  // Stage 4: split products for the triangle normal.
  logic signed [PLW-1:0]   pl_r [3];
  logic signed [PHW-1:0]   ph_r [3];
  logic        [RLW-1:0]   rl_r [3];
  logic        [RHW-1:0]   rh_r [3];
  logic                    sep4_r;

  // Stage 5 and 6: recombine halves, then sum components.
  logic signed [SW-1:0]    t5_r  [3];
  logic signed [SW-1:0]    rt5_r [3];
  logic                    sep5_r;
  logic signed [SW-1:0]    ps6_r;
  logic signed [SW-1:0]    rs6_r;
  logic                    sep6_r;

  logic                    ovl_r;

  assign h[0] = half_x;
  assign h[1] = half_y;
  assign h[2] = half_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        v[i][k]  = q_data[(i*3+k)*VW +: VW];
        e[i][k]  = q_data[(9+i*3+k)*VW +: VW];
        ae[i][k] = q_data[(18+i*3+k)*VW +: VW];
      end
    end
  end

  assign adv       = !vld_r[NSTG-1] || out_ready;
  assign q_pop     = adv && !q_stat.empty;
  assign out_valid = vld_r[NSTG-1];
  assign out_overlaps = ovl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], !q_stat.empty};
    end
  end

  // A box normal separates when all three vertices lie beyond the same face.
  always_comb begin
    logic all_hi;
    logic all_lo;
    bsep_c = 1'b0;
    for (int k = 0; k < 3; k++) begin
      all_hi = 1'b1;
      all_lo = 1'b1;
      for (int i = 0; i < 3; i++) begin
        all_hi &= (BW'(v[i][k]) > $signed(BW'({1'b0, h[k]})));
        all_lo &= (BW'(v[i][k]) < -$signed(BW'({1'b0, h[k]})));
      end
      bsep_c |= all_hi | all_lo;
    end
  end

  always_comb begin
    np_c[0][0] = e[0][1] * e[1][2];
    np_c[0][1] = e[0][2] * e[1][1];
    np_c[1][0] = e[0][2] * e[1][0];
    np_c[1][1] = e[0][0] * e[1][2];
    np_c[2][0] = e[0][0] * e[1][1];
    np_c[2][1] = e[0][1] * e[1][0];
  end

  // Axis a of edge i is box axis a crossed with the edge. Vertices i and
  // i+1 project to the same point, so vertices i and i+2 are enough.
  always_comb begin
    int u;
    int w;
    int j;
    for (int i = 0; i < 3; i++) begin
      for (int a = 0; a < 3; a++) begin
        u = (a + 1) % 3;
        w = (a + 2) % 3;
        for (int s = 0; s < 2; s++) begin
          j = (s == 0) ? i : (i + 2) % 3;
          m_c[i][a][s][0] = e[i][u] * v[j][w];
          m_c[i][a][s][1] = e[i][w] * v[j][u];
        end
        rp_c[i][a][0] = h[u] * ae[i][w];
        rp_c[i][a][1] = h[w] * ae[i][u];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      n_nxt[k] = NW'(np_r[k][0]) - NW'(np_r[k][1]);
    end
    for (int i = 0; i < 3; i++) begin
      for (int a = 0; a < 3; a++) begin
        for (int s = 0; s < 2; s++) begin
          p_nxt[i][a][s] = ESW'(m_r[i][a][s][0]) - ESW'(m_r[i][a][s][1]);
        end
        r_nxt[i][a] = ERW'(rp_r[i][a][0]) + ERW'(rp_r[i][a][1]);
      end
    end
  end

  always_comb begin
    logic signed [ECW-1:0] pa;
    logic signed [ECW-1:0] pb;
    logic signed [ECW-1:0] rr;
    esep_c = 1'b0;
    for (int i = 0; i < 3; i++) begin
      for (int a = 0; a < 3; a++) begin
        pa = ECW'(p2_r[i][a][0]);
        pb = ECW'(p2_r[i][a][1]);
        rr = $signed(ECW'(r2_r[i][a]));
        esep_c |= (pa > rr && pb > rr) || (pa < -rr && pb < -rr);
      end
    end
    for (int k = 0; k < 3; k++) begin
      an_c[k] = n2_r[k][NW-1] ? NW'(-n2_r[k]) : NW'(n2_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      np_r   <= np_c;
      m_r    <= m_c;
      rp_r   <= rp_c;
      bsep_r <= bsep_c;
      for (int k = 0; k < 3; k++) begin
        v0_1_r[k] <= v[0][k];
      end

      n2_r   <= n_nxt;
      p2_r   <= p_nxt;
      r2_r   <= r_nxt;
      v0_2_r <= v0_1_r;
      sep2_r <= bsep_r;

      n3_r   <= n2_r;
      an3_r  <= an_c;
      v0_3_r <= v0_2_r;
      sep3_r <= sep2_r | esep_c;

      for (int k = 0; k < 3; k++) begin
        pl_r[k] <= $signed({1'b0, n3_r[k][NL-1:0]}) * v0_3_r[k];
        ph_r[k] <= $signed(n3_r[k][NW-1:NL]) * v0_3_r[k];
        rl_r[k] <= an3_r[k][NL-1:0] * h[k];
        rh_r[k] <= an3_r[k][NW-1:NL] * h[k];
      end
      sep4_r <= sep3_r;

      for (int k = 0; k < 3; k++) begin
        t5_r[k]  <= (SW'(ph_r[k]) <<< NL) + SW'(pl_r[k]);
        rt5_r[k] <= $signed((SW'(rh_r[k]) << NL) + SW'(rl_r[k]));
      end
      sep5_r <= sep4_r;

      ps6_r  <= t5_r[0] + t5_r[1] + t5_r[2];
      rs6_r  <= rt5_r[0] + rt5_r[1] + rt5_r[2];
      sep6_r <= sep5_r;

      ovl_r  <= !(sep6_r || (ps6_r > rs6_r) || (ps6_r < -rs6_r));
    end
  end

endmodule
`default_nettype wire

FILE: sv/tbo_checker.sv
`default_nettype none
module tbo_checker import tbo_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_tready,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [OUT_W-1:0] out_tdata,
  input wire logic             cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_W-1:1] == '0)
    else $error("result padding bits not zero");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port not ready");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat right after reset");

  a_reset_in: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready right after reset");

endmodule

bind triangle_box_overlap_test_core tbo_checker u_tbo_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_ready  (cfg_ready)
);
`default_nettype wire
